// File: rtl/b64enc_pkg.sv
// shared types, constants and the character table for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [5:0] SEXTET_MASK = 6'h3f;

    // one 24-bit group ready for the character stage
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pads;
        logic        fin;
    } group_t;

    // maps one 6-bit slice to its ascii character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = PLUS_CHAR;
        else
            c = SLASH_CHAR;
        return c;
    endfunction

endpackage

// File: rtl/b64enc_byte_if.sv
// valid/ready channel carrying raw message bytes
// no dependencies
`timescale 1ns / 1ps

interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: rtl/b64enc_char_if.sv
// valid/ready channel carrying encoded characters
// no dependencies
`timescale 1ns / 1ps

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       last_char;

    modport source (output valid, output code_char, output last_char, input ready);
    modport sink (input valid, input code_char, input last_char, output ready);
endinterface

// File: rtl/base64_stream_encoder_top.sv
// Base64 stream encoder with the standard alphabet. One byte is taken per cycle
// while the group queue has room; every third byte, or any byte flagged final,
// forms a group of four characters, padded with '=' when the final group is
// short, and last_char marks the closing character. Characters leave one per
// cycle from a registered output while char_out.ready is high, so the character
// stage sets the sustained rate. The group queue lets bytes keep arriving while
// earlier groups are still being sent out or the output is stalled.
// depends on b64enc_pkg, b64enc_byte_if, b64enc_char_if, front, queue, back
`timescale 1ns / 1ps

module base64_stream_encoder_top #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    b64enc_byte_if.sink   byte_in,
    b64enc_char_if.source char_out
);

    logic               push;
    b64enc_pkg::group_t push_group;
    logic               full;
    logic               pop;
    b64enc_pkg::group_t pop_group;
    logic               empty;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push       (push),
        .push_group (push_group),
        .queue_full (full)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (full),
        .pop        (pop),
        .pop_group  (pop_group),
        .empty      (empty)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_group (pop_group),
        .empty     (empty),
        .pop       (pop),
        .char_out  (char_out)
    );

endmodule

// File: rtl/b64enc_front.sv
// front stage: collects bytes into 24-bit groups and pushes finished groups
// depends on b64enc_pkg, b64enc_byte_if
`timescale 1ns / 1ps

module b64enc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    b64enc_byte_if.sink          byte_in,
    output logic                 push,
    output b64enc_pkg::group_t   push_group,
    input  logic                 queue_full
);

    logic [15:0] pending_reg, pending_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pos;
    logic        emit;
    logic        accept;

    assign byte_in.ready = !queue_full;
    assign accept = byte_in.valid && byte_in.ready;

    // unused count value three behaves as a full pair pending
    assign pos  = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
    assign emit = (pos == 2'd2) || byte_in.final_byte;
    assign push = accept && emit;

    always_comb
    begin
        push_group.fin = byte_in.final_byte;
        case (pos)
            2'd0:
            begin
                push_group.bits = {byte_in.data_byte, 16'h0000};
                push_group.pads = 2'd2;
            end
            2'd1:
            begin
                push_group.bits = {pending_reg[15:8], byte_in.data_byte, 8'h00};
                push_group.pads = 2'd1;
            end
            default:
            begin
                push_group.bits = {pending_reg, byte_in.data_byte};
                push_group.pads = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        if (accept)
        begin
            if (emit)
            begin
                pending_next = 16'h0000;
                pos_next     = 2'd0;
            end
            else if (pos == 2'd0)
            begin
                pending_next = {byte_in.data_byte, 8'h00};
                pos_next     = 2'd1;
            end
            else
            begin
                pending_next = {pending_reg[15:8], byte_in.data_byte};
                pos_next     = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            pos_reg     <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// File: rtl/b64enc_queue.sv
// small group queue between the front and back stages
// depends on b64enc_pkg
`timescale 1ns / 1ps

module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64enc_pkg::group_t push_group,
    output logic               full,
    input  logic               pop,
    output b64enc_pkg::group_t pop_group,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64enc_pkg::group_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_group = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/b64enc_back.sv
// back stage: turns each queued group into four characters, one per cycle while char_out.ready allows
// depends on b64enc_pkg, b64enc_char_if
`timescale 1ns / 1ps

module b64enc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  b64enc_pkg::group_t pop_group,
    input  logic               empty,
    output logic               pop,
    b64enc_char_if.source      char_out
);

    b64enc_pkg::group_t group_reg, group_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       produce;
    logic       group_done;
    logic [5:0] sextet;
    logic       is_pad;

    assign char_out.valid     = ovalid_reg;
    assign char_out.code_char = char_reg;
    assign char_out.last_char = last_reg;

    // output register frees up when empty or taken this cycle
    assign produce    = busy_reg && (!ovalid_reg || char_out.ready);
    assign group_done = produce && (idx_reg == 2'd3);
    assign pop        = !empty && (!busy_reg || group_done);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = group_reg.bits[23:18];
            2'd1:    sextet = group_reg.bits[17:12];
            2'd2:    sextet = group_reg.bits[11:6];
            default: sextet = group_reg.bits[5:0];
        endcase
        sextet = sextet & b64enc_pkg::SEXTET_MASK;
        // pads cover the tail slots of the group
        is_pad = ({1'b0, idx_reg} >= (3'd4 - {1'b0, group_reg.pads}));
    end

    always_comb
    begin
        group_next  = group_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;

        if (ovalid_reg && char_out.ready)
            ovalid_next = 1'b0;

        if (produce)
        begin
            ovalid_next = 1'b1;
            char_next   = is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_char(sextet);
            last_next   = group_reg.fin && (idx_reg == 2'd3);
            idx_next    = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
                busy_next = 1'b0;
        end

        if (pop)
        begin
            group_next = pop_group;
            busy_next  = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
